// ----- hdl/iterative_dfs_discovery_order_macros.svh -----
// Assertion macros shared by the checker of the depth-first search block.
// Depends on nothing; included by the checker file.
`ifndef ITERATIVE_DFS_DISCOVERY_ORDER_MACROS_SVH
`define ITERATIVE_DFS_DISCOVERY_ORDER_MACROS_SVH
// Implication checked on every clock edge out of reset.
`define DFS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define DFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hdl/dfs_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types of the depth-first search block.
// Depends on nothing.
package dfs_pkg;
    localparam int VERTEX_SLOTS = 64;
    localparam int EDGE_SLOTS   = 1024;
    localparam int VW = $clog2(VERTEX_SLOTS);
    localparam int EW = $clog2(EDGE_SLOTS);
    localparam int CW = VW + 1;
    localparam int LW = EW + 1;
    localparam logic [LW-1:0] NO_EDGE = LW'(EDGE_SLOTS);

    // edge store access from the sequencer
    typedef struct packed {
        logic          we;
        logic [EW-1:0] waddr;
        logic [VW-1:0] wtarget;
        logic [LW-1:0] wlink;
        logic [EW-1:0] raddr;
    } edge_req_t;
endpackage

// ----- hdl/dfs_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module dfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/dfs_edge_store.sv -----
`timescale 1ns / 1ps
// Edge store: target and link memories, one read and one write per cycle.
// Depends on dfs_pkg and dfs_ram.
module dfs_edge_store
    import dfs_pkg::*;
(
    input  logic          clk,
    input  edge_req_t     req,
    output logic [VW-1:0] rd_target,
    output logic [LW-1:0] rd_link
);
    dfs_ram #(.WIDTH(VW), .DEPTH(EDGE_SLOTS)) u_target (
        .clk(clk), .we(req.we), .waddr(req.waddr), .wdata(req.wtarget),
        .raddr(req.raddr), .rdata(rd_target)
    );
    dfs_ram #(.WIDTH(LW), .DEPTH(EDGE_SLOTS)) u_link (
        .clk(clk), .we(req.we), .waddr(req.waddr), .wdata(req.wlink),
        .raddr(req.raddr), .rdata(rd_link)
    );
endmodule

// ----- hdl/iterative_dfs_discovery_order.sv -----
`timescale 1ns / 1ps
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | source_vertex target_vertex carries_edge last_item
//  out     | out_valid | out_stall | vertex discovery_index last_vertex edges_dropped
//  cfg     | cfg_we    | -         | cfg_data (num_vertices)
// An edge beat is accepted in S_IDLE, stored in S_LOAD. A last beat starts the DFS:
// S_ROOT tries each root, a new one goes to S_POP; a pop runs S_POP, S_POPRD, S_HEAD
// (stack read, then list head read); an edge runs S_EDGE, S_WAIT, S_CHECK (registered
// edge read plus a wait); then one result beat per vertex, held by out_stall. Reset
// clears list heads, visited bits and counters at once through flip-flop valid bits.
// Depends on dfs_pkg, dfs_edge_store, dfs_ram.
module iterative_dfs_discovery_order
    import dfs_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [6:0]    cfg_data,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [5:0]    source_vertex,
    input  logic [5:0]    target_vertex,
    input  logic          carries_edge,
    input  logic          last_item,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [5:0]    vertex,
    output logic [5:0]    discovery_index,
    output logic          last_vertex,
    output logic          edges_dropped
);
    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_ROOT, S_POP, S_POPRD, S_HEAD, S_EDGE, S_WAIT, S_CHECK, S_EMIT
    } state_t;

    state_t        state_reg;
    logic [6:0]    nv_cfg_reg;
    logic [VW-1:0] src_reg, dst_reg;
    logic          last_reg, edge_reg;
    logic [VERTEX_SLOTS-1:0] head_ok_reg, visited_reg;
    logic [CW-1:0] count_reg, level_reg, root_reg, emit_reg;
    logic [LW-1:0] fill_reg, link_reg;
    logic [VW-1:0] pop_reg;
    logic          drop_reg;
    logic [CW-1:0] nv;
    logic [VW-1:0] stk_rd;
    logic [VW-1:0] tgt_rd;
    logic [LW-1:0] lnk_rd;
    logic          stk_we;
    logic [VW-1:0] stk_wdata;
    edge_req_t     ereq;
    logic [LW-1:0] head_src;
    logic [LW-1:0] head_rd;
    logic [VW-1:0] head_raddr;
    logic          disc_we;
    logic [VW-1:0] disc_waddr;
    logic [VW-1:0] disc_raddr;
    logic [VW-1:0] disc_rd;

    // effective vertex count: zero counts as one, clamp above slots
    always_comb
    begin
        if (nv_cfg_reg == 7'd0)
            nv = CW'(1);
        else if (nv_cfg_reg > 7'(VERTEX_SLOTS))
            nv = CW'(VERTEX_SLOTS);
        else
            nv = CW'(nv_cfg_reg);
    end

    // list heads: read the incoming source while idle, the popped vertex while popping
    assign head_raddr = (state_reg == S_POPRD) ? stk_rd : source_vertex;

    dfs_ram #(.WIDTH(LW), .DEPTH(VERTEX_SLOTS)) u_heads (
        .clk(clk), .we(ereq.we), .waddr(src_reg), .wdata(fill_reg),
        .raddr(head_raddr), .rdata(head_rd)
    );

    assign head_src = head_ok_reg[src_reg] ? head_rd : NO_EDGE;

    // edge memory port: write on load, read the current link while scanning
    always_comb
    begin
        ereq.we      = (state_reg == S_LOAD) && edge_reg && (CW'(src_reg) < nv)
                       && (CW'(dst_reg) < nv) && (fill_reg < NO_EDGE);
        ereq.waddr   = fill_reg[EW-1:0];
        ereq.wtarget = dst_reg;
        ereq.wlink   = head_src;
        ereq.raddr   = link_reg[EW-1:0];
    end

    dfs_edge_store u_edges (
        .clk(clk), .req(ereq), .rd_target(tgt_rd), .rd_link(lnk_rd)
    );

    // vertex stack, depth VERTEX_SLOTS; read address is the top entry
    dfs_ram #(.WIDTH(VW), .DEPTH(VERTEX_SLOTS)) u_stack (
        .clk(clk), .we(stk_we), .waddr(level_reg[VW-1:0]), .wdata(stk_wdata),
        .raddr(VW'(level_reg - CW'(1))), .rdata(stk_rd)
    );

    always_comb
    begin
        stk_we    = 1'b0;
        stk_wdata = root_reg[VW-1:0];
        if (state_reg == S_ROOT && !visited_reg[root_reg[VW-1:0]] && root_reg < nv)
            stk_we = level_reg < CW'(VERTEX_SLOTS);
        if (state_reg == S_CHECK && (CW'(tgt_rd) < nv) && !visited_reg[tgt_rd])
        begin
            stk_we    = level_reg < CW'(VERTEX_SLOTS);
            stk_wdata = tgt_rd;
        end
    end

    // discovery numbers: write on each discovery, read one beat ahead while emitting
    always_comb
    begin
        disc_we    = (state_reg == S_ROOT && root_reg < nv
                      && !visited_reg[root_reg[VW-1:0]])
                     || (state_reg == S_CHECK && CW'(tgt_rd) < nv && !visited_reg[tgt_rd]);
        disc_waddr = (state_reg == S_ROOT) ? root_reg[VW-1:0] : tgt_rd;
        if (state_reg != S_EMIT)
            disc_raddr = '0;
        else if (out_stall)
            disc_raddr = emit_reg[VW-1:0];
        else
            disc_raddr = emit_reg[VW-1:0] + VW'(1);
    end

    dfs_ram #(.WIDTH(VW), .DEPTH(VERTEX_SLOTS)) u_disc (
        .clk(clk), .we(disc_we), .waddr(disc_waddr), .wdata(count_reg[VW-1:0]),
        .raddr(disc_raddr), .rdata(disc_rd)
    );

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = (state_reg == S_EMIT);
    assign vertex          = emit_reg[VW-1:0];
    assign discovery_index = disc_rd;
    assign last_vertex     = (emit_reg + CW'(1) == nv);
    assign edges_dropped   = drop_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            src_reg <= source_vertex;
            dst_reg <= target_vertex;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            nv_cfg_reg  <= 7'd64;
            head_ok_reg <= '0;
            visited_reg <= '0;
            count_reg   <= '0;
            level_reg   <= '0;
            root_reg    <= '0;
            emit_reg    <= '0;
            fill_reg    <= '0;
            link_reg    <= NO_EDGE;
            pop_reg     <= '0;
            drop_reg    <= 1'b0;
            last_reg    <= 1'b0;
            edge_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                nv_cfg_reg <= cfg_data;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg  <= last_item;
                        edge_reg  <= carries_edge;
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    if (ereq.we)
                    begin
                        head_ok_reg[src_reg] <= 1'b1;
                        fill_reg             <= fill_reg + LW'(1);
                    end
                    else if (edge_reg)
                        drop_reg <= 1'b1;
                    root_reg  <= '0;
                    state_reg <= last_reg ? S_ROOT : S_IDLE;
                end
                S_ROOT:
                begin
                    // try next root; discover and push when unvisited
                    if (root_reg >= nv)
                    begin
                        emit_reg  <= '0;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        root_reg <= root_reg + CW'(1);
                        if (!visited_reg[root_reg[VW-1:0]])
                        begin
                            visited_reg[root_reg[VW-1:0]] <= 1'b1;
                            count_reg <= count_reg + CW'(1);
                            if (stk_we)
                                level_reg <= level_reg + CW'(1);
                            state_reg <= S_POP;
                        end
                    end
                end
                S_POP:
                begin
                    // wait for the top entry read; drop back to roots when empty
                    if (level_reg == '0)
                        state_reg <= S_ROOT;
                    else
                        state_reg <= S_POPRD;
                end
                S_POPRD:
                begin
                    // pop the top entry; its list head read is under way
                    level_reg <= level_reg - CW'(1);
                    pop_reg   <= stk_rd;
                    state_reg <= S_HEAD;
                end
                S_HEAD:
                begin
                    link_reg  <= head_ok_reg[pop_reg] ? head_rd : NO_EDGE;
                    state_reg <= S_EDGE;
                end
                S_EDGE:
                begin
                    if (link_reg >= NO_EDGE)
                        state_reg <= S_POP;
                    else
                        state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (CW'(tgt_rd) < nv && !visited_reg[tgt_rd])
                    begin
                        visited_reg[tgt_rd] <= 1'b1;
                        count_reg <= count_reg + CW'(1);
                        if (stk_we)
                            level_reg <= level_reg + CW'(1);
                    end
                    link_reg  <= lnk_rd;
                    state_reg <= S_EDGE;
                end
                S_EMIT:
                begin
                    if (!out_stall)
                    begin
                        if (last_vertex)
                        begin
                            head_ok_reg <= '0;
                            visited_reg <= '0;
                            count_reg   <= '0;
                            level_reg   <= '0;
                            fill_reg    <= '0;
                            drop_reg    <= 1'b0;
                            state_reg   <= S_IDLE;
                        end
                        emit_reg <= emit_reg + CW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- hdl/dfs_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the depth-first search block, with its bind.
// Depends on the assertion macro header.
`include "iterative_dfs_discovery_order_macros.svh"
module dfs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [5:0] vertex,
    input logic [5:0] discovery_index,
    input logic       last_vertex
);
    `DFS_ASSERT_IMPL(a_no_in_while_out, clk, rst_n, out_valid, in_stall,
        "input open during output")
    `DFS_ASSERT_NEXT(a_vertex_steps, clk, rst_n, out_valid && !out_stall && !last_vertex,
        out_valid && vertex == $past(vertex) + 6'd1, "vertex order broken")
    `DFS_ASSERT_IMPL(a_first_vertex, clk, rst_n, !out_valid ##1 out_valid,
        vertex == 6'd0, "first beat not vertex 0")
    `DFS_ASSERT_IMPL(a_root_zero, clk, rst_n, out_valid && vertex == 6'd0,
        discovery_index == 6'd0, "vertex 0 not first")
    `DFS_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(vertex), "stalled beat moved")
endmodule

bind iterative_dfs_discovery_order dfs_checker u_dfs_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .vertex(vertex),
    .discovery_index(discovery_index), .last_vertex(last_vertex)
);
